@@ src/bqen_pkg.sv @@
// bqen_pkg: shared constants, types and codes for the bit-quad Euler number block.
// No dependencies.
`timescale 1ns / 1ps
package bqen_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int CFG_W        = 13;
    localparam int CMP_W        = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CNT_W        = 25;
    localparam int NUM_W        = CNT_W + 3;
    localparam int OUT_W        = 24;
    localparam int PIX_W        = 8;
    localparam int IDX_W        = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_CONNECTIVITY = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             pix_bit;
        logic             quad_ok;
        logic             last;
        logic [COL_W-1:0] col;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] c3;
        logic [CNT_W-1:0] cd;
    } t_counts;

endpackage

@@ src/bqen_line_ram.sv @@
// bqen_line_ram: 1-bit wide line buffer, one write and one registered read port.
// Write-first: a read of the address written at the same edge returns the new bit.
`timescale 1ns / 1ps
module bqen_line_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    output logic          o_rd_data
);

    logic r_mem [DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/bqen_quad_count.sv @@
// bqen_quad_count: quad stage; reads the line buffer, classifies the 2x2 quad,
// updates C1/C3/Cd and writes the pixel back. Uses bqen_pkg and bqen_line_ram.
`timescale 1ns / 1ps
module bqen_quad_count
    import bqen_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_item   i_item,
    output logic    o_free,
    input  logic    i_res_free,
    output logic    o_res_valid,
    output t_counts o_counts
);

    logic             r_v;
    t_item            r_item;
    logic             r_ul;
    logic             r_left;
    logic [CNT_W-1:0] r_c1;
    logic [CNT_W-1:0] r_c3;
    logic [CNT_W-1:0] r_cd;

    logic             up;
    logic             move;
    logic [3:0]       quad;
    logic [2:0]       ones;
    logic             is_single;
    logic             is_triple;
    logic             is_diag;
    logic [CNT_W-1:0] n_c1;
    logic [CNT_W-1:0] n_c3;
    logic [CNT_W-1:0] n_cd;

    bqen_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (i_take),
        .i_rd_addr (i_item.col),
        .i_wr_en   (move),
        .i_wr_addr (r_item.col),
        .i_wr_data (r_item.pix_bit),
        .o_rd_data (up)
    );

    assign move   = r_v && (!r_item.last || i_res_free);
    assign o_free = !r_v || move;

    always_comb begin
        quad      = {r_ul, up, r_left, r_item.pix_bit};
        ones      = {2'b0, quad[0]} + {2'b0, quad[1]} + {2'b0, quad[2]} + {2'b0, quad[3]};
        is_single = r_item.quad_ok && (ones == 3'd1);
        is_triple = r_item.quad_ok && (ones == 3'd3);
        is_diag   = r_item.quad_ok && ((quad == 4'b1001) || (quad == 4'b0110));
        n_c1      = r_c1 + {{(CNT_W-1){1'b0}}, is_single};
        n_c3      = r_c3 + {{(CNT_W-1){1'b0}}, is_triple};
        n_cd      = r_cd + {{(CNT_W-1){1'b0}}, is_diag};
    end

    assign o_res_valid = move && r_item.last;
    assign o_counts    = '{c1: n_c1, c3: n_c3, cd: n_cd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_ul   <= 1'b0;
            r_left <= 1'b0;
            r_c1   <= '0;
            r_c3   <= '0;
            r_cd   <= '0;
        end else begin
            if (o_free) begin
                r_v <= i_take;
            end
            if (move) begin
                r_ul   <= up;
                r_left <= r_item.pix_bit;
                if (r_item.last) begin
                    r_c1 <= '0;
                    r_c3 <= '0;
                    r_cd <= '0;
                end else begin
                    r_c1 <= n_c1;
                    r_c3 <= n_c3;
                    r_cd <= n_cd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= i_item;
        end
    end

endmodule

@@ src/bqen_result.sv @@
// bqen_result: frame result path; forms C1 - C3 +/- 2Cd, divides by 4 toward zero
// and holds the result for the output channel. Uses bqen_pkg.
`timescale 1ns / 1ps
module bqen_result
    import bqen_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_conn,
    input  logic             i_res_valid,
    input  t_counts          i_counts,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_euler_number
);

    logic             r2_v;
    t_counts          r2_counts;
    logic             r3_v;
    logic [NUM_W-1:0] r3_num;
    logic             r_o_v;
    logic [OUT_W-1:0] r_o_q;

    logic             out_free;
    logic             s3_free;
    logic [NUM_W-1:0] a1;
    logic [NUM_W-1:0] a3;
    logic [NUM_W-1:0] ad;
    logic [NUM_W-1:0] n_num;
    logic [NUM_W-1:0] adj;

    assign out_free = !r_o_v || !i_stall;
    assign s3_free  = !r3_v || out_free;
    assign o_free   = !r2_v || s3_free;

    always_comb begin
        a1    = {3'b0, r2_counts.c1};
        a3    = {3'b0, r2_counts.c3};
        ad    = {2'b0, r2_counts.cd, 1'b0};
        n_num = i_conn ? (a1 - a3 - ad) : (a1 - a3 + ad);
        adj   = r3_num + (r3_num[NUM_W-1] ? NUM_W'(3) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (o_free) begin
                r2_v <= i_res_valid;
            end
            if (s3_free) begin
                r3_v <= r2_v;
            end
            if (out_free) begin
                r_o_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r2_counts <= i_counts;
        end
        if (s3_free && r2_v) begin
            r3_num <= n_num;
        end
        if (out_free && r3_v) begin
            r_o_q <= adj[OUT_W+1:2];
        end
    end

    assign o_valid        = r_o_v;
    assign o_euler_number = r_o_q;

endmodule

@@ src/bit_quad_euler_number_top.sv @@
// bit_quad_euler_number_top: Euler number of a binary raster image by bit-quad counting.
// Uses bqen_pkg, bqen_quad_count and bqen_result.
//
// channel   direction  handshake             payload
// pixel     in         i_valid / o_stall     i_pixel[7:0]
// result    out        o_valid / i_stall     o_euler_number[23:0] (signed)
// config    in         i_cfg_we              i_cfg_addr[1:0], i_cfg_wdata[12:0]
//
// One pixel per cycle; a transaction is accepted each cycle the quad stage can drain,
// which it can unless it holds a frame's last pixel and the result path is full.
// A frame's result passes the quad stage, then result stages r2, r3 and r_o before o_valid.
// A stalled result stops input only once the result pipeline behind it is also full.
// Synchronous active-low reset; the line buffer is not cleared (row 0 ignores what it reads).
`timescale 1ns / 1ps
module bit_quad_euler_number_top
    import bqen_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_euler_number,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    logic             r_conn;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             take;
    logic             qc_free;
    logic             res_free;
    logic             res_valid;
    t_counts          counts;
    t_item            item;
    logic [COL_W:0]   col_next;
    logic [ROW_W:0]   row_next;
    logic             last_col;
    logic             last_row;

    assign take    = i_valid && qc_free;
    assign o_stall = !qc_free;

    always_comb begin
        col_next = {1'b0, r_col} + {{COL_W{1'b0}}, 1'b1};
        row_next = {1'b0, r_row} + {{ROW_W{1'b0}}, 1'b1};
        last_col = (r_width == '0) || (CMP_W'(col_next) >= CMP_W'(r_width))
                || (col_next == (COL_W+1)'(MAX_WIDTH));
        last_row = (r_height == '0) || (CFG_W'(row_next) >= r_height)
                || (row_next == (ROW_W+1)'(HEIGHT_LIMIT));
        item.pix_bit = (i_pixel != '0);
        item.quad_ok = (r_col != '0) && (r_row != '0);
        item.last    = last_col && last_row;
        item.col     = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn   <= 1'b1;
            r_width  <= CFG_W'(4096);
            r_height <= CFG_W'(4096);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_CONNECTIVITY: begin
                        r_conn <= i_cfg_wdata[0];
                    end
                    CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_wdata;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (take) begin
                if (last_col && last_row) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= row_next[ROW_W-1:0];
                end else begin
                    r_col <= col_next[COL_W-1:0];
                end
            end
        end
    end

    bqen_quad_count u_quad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (item),
        .o_free      (qc_free),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_counts    (counts)
    );

    bqen_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_conn         (r_conn),
        .i_res_valid    (res_valid),
        .i_counts       (counts),
        .o_free         (res_free),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_euler_number (o_euler_number)
    );

endmodule
